// ===== design/fpms_pkg.sv =====
// Shared types, constants and the case-folding function of the fuzzy pattern scorer.
package fpms_pkg;

    localparam int CHAR_W    = 8;
    localparam int CHARS     = 8;
    localparam int LEN_W     = 4;
    localparam int PBYTES_W  = CHARS * CHAR_W;
    localparam int SCORE_W   = 7;
    localparam int RESULT_W  = 9;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 1;

    typedef logic [CHAR_W-1:0] t_char;
    typedef t_char [CHARS-1:0] t_pattern;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LENGTH = 1'b0,
        CFG_PATTERN_BYTES  = 1'b1
    } t_cfg_idx;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE      = 2'd0,
        KIND_SUBSTRING = 2'd1,
        KIND_SUBSEQ    = 2'd2,
        KIND_EMPTY     = 2'd3
    } t_kind;

    localparam logic [RESULT_W-1:0] FULL_SCORE     = 9'd100;
    localparam logic [SCORE_W-1:0]  ADJACENT_BONUS = 7'd10;

    // Control that the top level broadcasts to every cell each cycle.
    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctl;

    // ASCII upper case folds to lower case; every other byte stays as it is.
    function automatic t_char fold(input t_char c);
        if (c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'h20;
        end
        return c;
    endfunction

endpackage

// ===== design/fpms_if.sv =====
// Channel interfaces of the fuzzy pattern scorer: text words, score words, register writes.
interface fpms_text_if;
    logic                         valid;
    logic                         ready;
    logic [fpms_pkg::CHAR_W-1:0]  text_byte;
    logic                         last_byte;

    modport source (output valid, output text_byte, output last_byte, input ready);
    modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

interface fpms_score_if;
    logic                                valid;
    logic                                ready;
    logic signed [fpms_pkg::RESULT_W-1:0] match_score;
    logic [fpms_pkg::KIND_W-1:0]          match_kind;

    modport source (output valid, output match_score, output match_kind, input ready);
    modport sink   (input valid, input match_score, input match_kind, output ready);
endinterface

interface fpms_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [fpms_pkg::CFG_IDX_W-1:0]   index;
    logic [fpms_pkg::PBYTES_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/fuzzy_pattern_match_scorer.sv =====
// Top level of the fuzzy pattern scorer: cell row, subsequence tracker and result register.
//
// Usage. Two registers are written over i_cfg while the block is idle: index 0 holds the
// pattern length (values above PATTERN_MAX act as PATTERN_MAX), index 1 the packed pattern
// bytes with character zero in the lowest byte. i_cfg is always ready.
// Text arrives on i_text, one byte per word, last_byte marking the end of a text. Every
// text gives exactly one score word on o_score, and only for its last byte.
// Throughput is one text byte per clock unless o_score stalls: every byte shifts through
// a row of PATTERN_MAX window cells and steps the subsequence tracker in the same cycle.
// The score of a text is valid in the cycle after its last byte is taken, held in a
// single output register.
// When the receiver stalls, that register keeps its word and i_text.ready drops only
// while a finished score waits and o_score.ready is low; a new text byte is taken in the
// same cycle the old score leaves.
// Reset (synchronous, active low) clears the pattern registers, the window, the position
// and match state and the output valid flag; no clearing pass is needed afterwards.
// Text positions saturate at TEXT_MAX-1; a substring score is 100 minus the start of the
// first occurrence, kept to its low nine bits.
module fuzzy_pattern_match_scorer #(
    parameter int PATTERN_MAX = 8,
    parameter int TEXT_MAX    = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fpms_text_if.sink     i_text,
    fpms_score_if.source  o_score,
    fpms_cfg_if.sink      i_cfg
);

    localparam int POS_W = $clog2(TEXT_MAX);
    localparam int CUR_W = $clog2(PATTERN_MAX + 1);
    localparam int LEN_W = fpms_pkg::LEN_W;

    // Configuration registers.
    logic [LEN_W-1:0]             r_len;
    logic [fpms_pkg::PBYTES_W-1:0] r_pbytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_pbytes <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (fpms_pkg::t_cfg_idx'(i_cfg.index))
                fpms_pkg::CFG_PATTERN_LENGTH: r_len    <= i_cfg.data[LEN_W-1:0];
                fpms_pkg::CFG_PATTERN_BYTES:  r_pbytes <= i_cfg.data;
            endcase
        end
    end

    assign i_cfg.ready = 1'b1;

    // Folded pattern characters and the length actually in use.
    fpms_pkg::t_pattern pattern;
    logic [LEN_W-1:0]   alen;

    always_comb begin
        for (int k = 0; k < fpms_pkg::CHARS; k++) begin
            pattern[k] = fpms_pkg::fold(r_pbytes[k*fpms_pkg::CHAR_W +: fpms_pkg::CHAR_W]);
        end
    end

    assign alen = (r_len > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : r_len;

    // Handshake. A byte is taken whenever the output register is free or being emptied.
    logic                r_out_valid;
    logic                accept;
    fpms_pkg::t_cell_ctl ctl;
    fpms_pkg::t_char     in_char;

    assign i_text.ready = !r_out_valid || o_score.ready;
    assign accept       = i_text.valid && i_text.ready;
    assign ctl.shift    = accept;
    assign ctl.clear    = accept && i_text.last_byte;
    assign in_char      = fpms_pkg::fold(i_text.text_byte);

    // Row of window cells, newest byte in cell zero. Cell k compares against pattern
    // character len-1-k, so the whole row agrees exactly when the window ends a match.
    fpms_pkg::t_char           win [PATTERN_MAX];
    logic [PATTERN_MAX-1:0]    cell_match;

    for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
        fpms_pkg::t_char  from_left;
        logic [LEN_W-1:0] tgt_idx;

        if (k == 0) begin : g_head
            assign from_left = in_char;
        end else begin : g_body
            assign from_left = win[k-1];
        end

        assign tgt_idx = alen - LEN_W'(k) - LEN_W'(1);

        fpms_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (ctl),
            .i_byte   (from_left),
            .i_target (pattern[tgt_idx[2:0]]),
            .i_used   (LEN_W'(k) < alen),
            .o_byte   (win[k]),
            .o_match  (cell_match[k])
        );
    end

    // Subsequence tracker, which also owns the text position.
    logic [POS_W-1:0]             pos;
    logic [CUR_W-1:0]             cursor_nxt;
    logic [fpms_pkg::SCORE_W-1:0] subseq_nxt;

    fpms_seq #(
        .PATTERN_MAX (PATTERN_MAX),
        .TEXT_MAX    (TEXT_MAX)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .i_char       (in_char),
        .i_len        (alen),
        .i_pattern    (pattern),
        .o_pos        (pos),
        .o_cursor_nxt (cursor_nxt),
        .o_score_nxt  (subseq_nxt)
    );

    // First substring occurrence. Nothing is found before len bytes of this text arrived.
    logic             r_seen,  n_seen;
    logic [POS_W-1:0] r_start, n_start;
    logic [POS_W:0]   pos_plus1;
    logic             found;

    assign pos_plus1 = {1'b0, pos} + 1'b1;
    assign found     = (alen != '0) && !r_seen && (pos_plus1 >= (POS_W+1)'(alen))
                       && (&cell_match);

    always_comb begin
        n_seen  = r_seen;
        n_start = r_start;
        if (accept && found) begin
            n_seen  = 1'b1;
            n_start = POS_W'(pos_plus1 - (POS_W+1)'(alen));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || ctl.clear) begin
            r_seen  <= 1'b0;
            r_start <= '0;
        end else begin
            r_seen  <= n_seen;
            r_start <= n_start;
        end
    end

    // Final score, taken from the state as it stands after the last byte.
    logic [fpms_pkg::RESULT_W-1:0] score_nxt;
    fpms_pkg::t_kind               kind_nxt;

    always_comb begin
        if (alen == '0) begin
            score_nxt = fpms_pkg::FULL_SCORE;
            kind_nxt  = fpms_pkg::KIND_EMPTY;
        end else if (n_seen) begin
            score_nxt = fpms_pkg::FULL_SCORE - fpms_pkg::RESULT_W'(n_start);
            kind_nxt  = fpms_pkg::KIND_SUBSTRING;
        end else if (LEN_W'(cursor_nxt) >= alen) begin
            score_nxt = fpms_pkg::RESULT_W'(subseq_nxt);
            kind_nxt  = fpms_pkg::KIND_SUBSEQ;
        end else begin
            score_nxt = '0;
            kind_nxt  = fpms_pkg::KIND_NONE;
        end
    end

    // Output register.
    logic [fpms_pkg::RESULT_W-1:0] r_score;
    fpms_pkg::t_kind               r_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.clear) begin
            r_out_valid <= 1'b1;
        end else if (o_score.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.clear) begin
            r_score <= score_nxt;
            r_kind  <= kind_nxt;
        end
    end

    assign o_score.valid       = r_out_valid;
    assign o_score.match_score = $signed(r_score);
    assign o_score.match_kind  = r_kind;

endmodule

// ===== design/fpms_cell.sv =====
// One window cell: holds a recent text byte, passes it on and compares its incoming byte.
module fpms_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fpms_pkg::t_cell_ctl i_ctl,
    input  fpms_pkg::t_char     i_byte,
    input  fpms_pkg::t_char     i_target,
    input  logic                i_used,
    output fpms_pkg::t_char     o_byte,
    output logic                o_match
);

    fpms_pkg::t_char r_byte;
    fpms_pkg::t_char n_byte;

    always_comb begin
        n_byte = r_byte;
        if (i_ctl.clear) begin
            n_byte = '0;
        end else if (i_ctl.shift) begin
            n_byte = i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
        end else begin
            r_byte <= n_byte;
        end
    end

    // The compare looks at the byte this cell holds once the current word has shifted in.
    assign o_byte  = r_byte;
    assign o_match = !i_used || (i_byte == i_target);

endmodule

// ===== design/fpms_seq.sv =====
// Greedy in-order subsequence tracker: text position, pattern cursor and running score.
module fpms_seq #(
    parameter int PATTERN_MAX = 8,
    parameter int TEXT_MAX    = 256
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  fpms_pkg::t_cell_ctl                   i_ctl,
    input  fpms_pkg::t_char                       i_char,
    input  logic [fpms_pkg::LEN_W-1:0]            i_len,
    input  fpms_pkg::t_pattern                    i_pattern,
    output logic [$clog2(TEXT_MAX)-1:0]           o_pos,
    output logic [$clog2(PATTERN_MAX+1)-1:0]      o_cursor_nxt,
    output logic [fpms_pkg::SCORE_W-1:0]          o_score_nxt
);

    localparam int POS_W = $clog2(TEXT_MAX);
    localparam int CUR_W = $clog2(PATTERN_MAX + 1);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(TEXT_MAX - 1);

    logic [POS_W-1:0]             r_pos,      n_pos;
    logic [CUR_W-1:0]             r_cursor,   n_cursor;
    logic [POS_W:0]               r_expected, n_expected;
    logic [fpms_pkg::SCORE_W-1:0] r_score,    n_score;
    logic [fpms_pkg::LEN_W-1:0]   cursor_ext;
    logic                         hit;

    assign cursor_ext = fpms_pkg::LEN_W'(r_cursor);
    assign hit = (cursor_ext < i_len) && (i_char == i_pattern[cursor_ext[2:0]]);

    always_comb begin
        n_pos      = r_pos;
        n_cursor   = r_cursor;
        n_expected = r_expected;
        n_score    = r_score;
        if (i_ctl.shift) begin
            if (hit) begin
                // A character right after the previous match, or a first match at position zero, earns the bonus.
                if ({1'b0, r_pos} == r_expected) begin
                    n_score = r_score + fpms_pkg::ADJACENT_BONUS + 7'd1;
                end else begin
                    n_score = r_score + 7'd1;
                end
                n_expected = {1'b0, r_pos} + 1'b1;
                n_cursor   = r_cursor + 1'b1;
            end
            if (r_pos != POS_LAST) begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_pos      <= '0;
            r_cursor   <= '0;
            r_expected <= '0;
            r_score    <= '0;
        end else begin
            r_pos      <= n_pos;
            r_cursor   <= n_cursor;
            r_expected <= n_expected;
            r_score    <= n_score;
        end
    end

    assign o_pos        = r_pos;
    assign o_cursor_nxt = n_cursor;
    assign o_score_nxt  = n_score;

endmodule

// ===== bench/fuzzy_score_checker.sv =====
// Channel monitor for the fuzzy pattern scorer: predicts each text's score and checks it.
module fuzzy_score_checker
    import fpms_pkg::*;
#(
    parameter int PATTERN_MAX = 8,
    parameter int TEXT_MAX    = 256
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    fpms_text_if  text_ch,
    fpms_score_if score_ch,
    fpms_cfg_if   cfg_ch,
    output int    o_fail_count,
    output int    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [RESULT_W-1:0] score;
        t_kind                      kind;
    } t_score_word;

    t_score_word scores_due[$];

    // Copy of the pattern registers as last written over the register channel.
    logic [LEN_W-1:0]    cfg_len;
    logic [PBYTES_W-1:0] cfg_chars;

    // Per-text matching state.
    t_char window_q [PATTERN_MAX];
    int    text_pos;
    bit    occ_found;
    int    occ_start;
    int    cursor_k;
    int    bonus_pos;
    int    run_score;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic t_char to_lower(input t_char b);
        if (b inside {[8'h41:8'h5A]}) begin
            return b ^ 8'h20;
        end
        return b;
    endfunction

    function automatic t_char pattern_at(input int k);
        return to_lower(cfg_chars[CHAR_W*k +: CHAR_W]);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t ns] MISMATCH: %s", $time, msg);
        o_fail_count++;
    endtask

    task automatic reset_text_state();
        for (int k = 0; k < PATTERN_MAX; k++) begin
            window_q[k] = '0;
        end
        text_pos  = 0;
        occ_found = 1'b0;
        occ_start = 0;
        cursor_k  = 0;
        bonus_pos = 0;
        run_score = 0;
    endtask

    // Advances the matching state by one text word; the last word of a text queues its score.
    task automatic score_text_byte(input t_char raw, input logic is_last);
        t_char       ch;
        int          n;
        int          p;
        bit          same;
        int          sc;
        t_score_word w;
        ch = to_lower(raw);
        n  = (cfg_len > PATTERN_MAX) ? PATTERN_MAX : int'(cfg_len);
        p  = text_pos;
        for (int k = PATTERN_MAX - 1; k > 0; k--) begin
            window_q[k] = window_q[k-1];
        end
        window_q[0] = ch;

        if (n > 0 && !occ_found && p + 1 >= n) begin
            same = 1'b1;
            for (int k = 0; k < n; k++) begin
                if (window_q[k] != pattern_at(n - 1 - k)) begin
                    same = 1'b0;
                end
            end
            if (same) begin
                occ_found = 1'b1;
                occ_start = p + 1 - n;
            end
        end

        if (cursor_k < n && ch == pattern_at(cursor_k)) begin
            if (p == bonus_pos) begin
                run_score += 10;
            end
            run_score += 1;
            bonus_pos = p + 1;
            cursor_k++;
        end

        if (text_pos < TEXT_MAX - 1) begin
            text_pos++;
        end

        if (is_last) begin
            if (n == 0) begin
                sc     = 100;
                w.kind = KIND_EMPTY;
            end else if (occ_found) begin
                sc     = 100 - occ_start;
                w.kind = KIND_SUBSTRING;
            end else if (cursor_k >= n) begin
                sc     = run_score;
                w.kind = KIND_SUBSEQ;
            end else begin
                sc     = 0;
                w.kind = KIND_NONE;
            end
            w.score = sc[RESULT_W-1:0];
            scores_due.push_back(w);
            reset_text_state();
        end
    endtask

    task automatic check_score();
        t_score_word w;
        if (scores_due.size() == 0) begin
            report_mismatch($sformatf("score word %0d kind %0d with no text pending",
                                      score_ch.match_score, score_ch.match_kind));
            return;
        end
        w = scores_due.pop_front();
        if (score_ch.match_score !== w.score) begin
            report_mismatch($sformatf("match_score %0d, expected %0d",
                                      score_ch.match_score, w.score));
        end
        if (score_ch.match_kind !== w.kind) begin
            report_mismatch($sformatf("match_kind %0d, expected %0d",
                                      score_ch.match_kind, w.kind));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_len   = '0;
            cfg_chars = '0;
            reset_text_state();
            scores_due.delete();
        end else begin
            if (text_ch.valid && text_ch.ready) begin
                score_text_byte(text_ch.text_byte, text_ch.last_byte);
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (t_cfg_idx'(cfg_ch.index))
                    CFG_PATTERN_LENGTH: cfg_len = cfg_ch.data[LEN_W-1:0];
                    CFG_PATTERN_BYTES:  cfg_chars = cfg_ch.data;
                    default: ;
                endcase
            end
            if (score_ch.valid && score_ch.ready) begin
                check_score();
            end
        end
        o_pending = scores_due.size();
    end

endmodule

// ===== bench/fuzzy_pattern_match_scorer_tb.sv =====
// Testbench top of the fuzzy pattern scorer: clock, reset, stimulus and the verdict.
module fuzzy_pattern_match_scorer_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fpms_pkg::*;

    localparam int PATTERN_MAX  = 8;
    localparam int TEXT_MAX     = 256;
    // The random part stops once this many text words have gone in, directed ones included.
    localparam int RANDOM_WORDS = 1300;
    // The last stretch of text runs with no idling on either side.
    localparam int QUIET_TAIL   = 200;
    // Phases that open with a text long enough to saturate the position counter.
    localparam int LONG_PHASE_A = 3;
    localparam int LONG_PHASE_B = 9;
    localparam int TIMEOUT_NS   = 5_000_000;

    typedef enum int {
        TEXT_NOISE,
        TEXT_PLANTED,
        TEXT_SPREAD
    } t_text_mode;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    fpms_text_if  text_ch();
    fpms_score_if score_ch();
    fpms_cfg_if   cfg_ch();

    int fail_count;
    int pending;

    bit    idling_on  = 1'b0;
    int    stall_left = 0;
    int    words_sent = 0;
    t_char text_q[$];
    string letters = "abcdABCD";

    // Shadow of what was last written, so the text builder can plant the pattern.
    logic [LEN_W-1:0]    cur_len   = '0;
    logic [PBYTES_W-1:0] cur_chars = '0;

    fuzzy_pattern_match_scorer #(
        .PATTERN_MAX(PATTERN_MAX),
        .TEXT_MAX   (TEXT_MAX)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_text (text_ch),
        .o_score(score_ch),
        .i_cfg  (cfg_ch)
    );

    fuzzy_score_checker #(
        .PATTERN_MAX(PATTERN_MAX),
        .TEXT_MAX   (TEXT_MAX)
    ) score_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .text_ch     (text_ch),
        .score_ch    (score_ch),
        .cfg_ch      (cfg_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver side. While idling is enabled, ready drops at random, so stalls land on
    // score words at random points of the run.
    initial begin
        score_ch.ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (stall_left == 0 && idling_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 7);
            end
            score_ch.ready <= (stall_left == 0);
            if (stall_left > 0) begin
                stall_left--;
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("fuzzy_pattern_match_scorer verification failed");
        $finish;
    end

    function automatic logic [PBYTES_W-1:0] pack_chars(input string s);
        logic [PBYTES_W-1:0] r;
        r = '0;
        for (int i = 0; i < s.len() && i < CHARS; i++) begin
            r[CHAR_W*i +: CHAR_W] = s[i];
        end
        return r;
    endfunction

    // Letters come out in either case at random; every other byte stays as it is.
    function automatic t_char flip_case(input t_char b);
        if (((b >= "a" && b <= "z") || (b >= "A" && b <= "Z")) && $urandom_range(0, 1)) begin
            return b ^ 8'h20;
        end
        return b;
    endfunction

    // Pattern characters are mostly from a small alphabet so that texts hit them often,
    // with NUL bytes to probe the cleared window, and any byte value now and then.
    function automatic t_char pick_pattern_char();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14) begin
            return letters[$urandom_range(0, 7)];
        end else if (r < 17) begin
            return 8'h00;
        end
        return t_char'($urandom_range(0, 255));
    endfunction

    function automatic t_char pick_text_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) begin
            return flip_case(cur_chars[CHAR_W*$urandom_range(0, CHARS-1) +: CHAR_W]);
        end else if (r < 7) begin
            return letters[$urandom_range(0, 7)];
        end
        return t_char'($urandom_range(0, 255));
    endfunction

    function automatic int active_len();
        return (cur_len > PATTERN_MAX) ? PATTERN_MAX : int'(cur_len);
    endfunction

    // Builds one text in text_q. A planted text carries the whole pattern at offset at;
    // a spread text carries the pattern characters in order with filler between them,
    // which is what drives the subsequence scoring.
    task automatic make_text(input int n, input t_text_mode mode, input int at);
        int plen;
        int k;
        plen = active_len();
        text_q.delete();
        for (int i = 0; i < n; i++) begin
            text_q.push_back(pick_text_char());
        end
        case (mode)
            TEXT_PLANTED: begin
                if (plen > 0 && at + plen <= n) begin
                    for (k = 0; k < plen; k++) begin
                        text_q[at+k] = flip_case(cur_chars[CHAR_W*k +: CHAR_W]);
                    end
                end
            end
            TEXT_SPREAD: begin
                k = 0;
                for (int i = 0; i < n; i++) begin
                    if (k < plen && (n - i <= plen - k || $urandom_range(0, 2) == 0)) begin
                        text_q[i] = flip_case(cur_chars[CHAR_W*k +: CHAR_W]);
                        k++;
                    end
                end
            end
            default: ;
        endcase
    endtask

    function automatic void load_text(input string s);
        text_q.delete();
        for (int i = 0; i < s.len(); i++) begin
            text_q.push_back(s[i]);
        end
    endfunction

    // Offers one text word. It starts at a falling edge, may idle first, and returns at
    // the rising edge where the word was taken. Valid is left high, so a following word
    // replaces it at the next falling edge unless that word idles first.
    task automatic send_word(input t_char b, input logic is_last);
        @(negedge i_clk);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            text_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        text_ch.valid     <= 1'b1;
        text_ch.text_byte <= b;
        text_ch.last_byte <= is_last;
        @(posedge i_clk);
        while (!text_ch.ready) @(posedge i_clk);
        words_sent++;
    endtask

    // Sends text_q; with close cleared the text stays open for a later phase to finish.
    task automatic send_text(input bit close);
        foreach (text_q[i]) begin
            send_word(text_q[i], close && i == text_q.size() - 1);
        end
    endtask

    // Drops text valid, waits for every pending score, then lets the output register
    // settle with a small margin before registers may be rewritten.
    task automatic wait_idle();
        @(negedge i_clk);
        text_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    // Writes both registers back to back. The unused upper bits of the length word are
    // random; only its low nibble is meaningful.
    task automatic write_pattern(input logic [LEN_W-1:0] len, input logic [PBYTES_W-1:0] chars);
        logic [PBYTES_W-1:0] len_word;
        len_word           = {$urandom, $urandom};
        len_word[LEN_W-1:0] = len;
        cur_len            = len;
        cur_chars          = chars;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_PATTERN_LENGTH;
        cfg_ch.data  <= len_word;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.index <= CFG_PATTERN_BYTES;
        cfg_ch.data  <= chars;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin
        int               phase;
        int               texts;
        int               n;
        int               at;
        int               plen;
        bit               long_phase;
        bit               open_text;
        logic [LEN_W-1:0] len;
        logic [PBYTES_W-1:0] chars;
        t_text_mode       mode;

        text_ch.valid     = 1'b0;
        text_ch.text_byte = '0;
        text_ch.last_byte = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = CFG_PATTERN_LENGTH;
        cfg_ch.data       = '0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Right after reset the pattern is empty, so any text scores 100.
        load_text("Q");
        send_text(1'b1);

        // Mixed-case pattern found as a substring at offset 1, then an in-order subsequence
        // with one adjacent hit, then a text shorter than the pattern, which must not match
        // on the cleared window.
        wait_idle();
        write_pattern(4'd3, pack_chars("AbC"));
        load_text("xABc");
        send_text(1'b1);
        load_text("aXbYc");
        send_text(1'b1);
        load_text("ab");
        send_text(1'b1);

        // A length above the maximum acts as a full eight-character pattern.
        wait_idle();
        write_pattern(4'hF, pack_chars("ABCDEFGH"));
        load_text("abcdefgh");
        send_text(1'b1);

        // All-ones pattern bytes against an all-ones text byte.
        wait_idle();
        write_pattern(4'd1, '1);
        text_q.delete();
        text_q.push_back(8'hFF);
        send_text(1'b1);

        // The pattern changes between two words of one text.
        wait_idle();
        write_pattern(4'd2, pack_chars("ab"));
        load_text("a");
        send_text(1'b0);
        wait_idle();
        write_pattern(4'd1, pack_chars("q"));
        load_text("Q");
        send_text(1'b1);

        // Random part, in phases. Each phase rewrites both registers while the block is
        // idle and then streams a handful of texts. Most texts are planted or spread
        // copies of the pattern with random content around them; the rest are noise. Two
        // phases open with a text that runs past the position limit, one with the pattern
        // late enough to give a negative substring score, one with it in the saturated
        // region. Now and then a phase leaves its last text open for the next phase.
        phase     = 0;
        open_text = 1'b0;
        while (words_sent < RANDOM_WORDS) begin
            wait_idle();
            long_phase = (phase == LONG_PHASE_A || phase == LONG_PHASE_B);
            case ($urandom_range(0, 9))
                0:       len = '0;
                1:       len = LEN_W'(PATTERN_MAX);
                2:       len = LEN_W'($urandom_range(PATTERN_MAX + 1, 15));
                default: len = LEN_W'($urandom_range(1, PATTERN_MAX));
            endcase
            if (long_phase && (len == 0 || len > PATTERN_MAX)) begin
                len = LEN_W'($urandom_range(1, PATTERN_MAX));
            end
            for (int k = 0; k < CHARS; k++) begin
                chars[CHAR_W*k +: CHAR_W] = pick_pattern_char();
            end
            write_pattern(len, chars);
            idling_on = (words_sent < RANDOM_WORDS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);

            if (open_text) begin
                make_text($urandom_range(1, 3), TEXT_NOISE, 0);
                send_text(1'b1);
                open_text = 1'b0;
            end

            plen  = active_len();
            texts = $urandom_range(3, 10);
            for (int t = 0; t < texts; t++) begin
                if (long_phase && t == 0) begin
                    n  = $urandom_range(TEXT_MAX, TEXT_MAX + 24);
                    at = (phase == LONG_PHASE_A) ? $urandom_range(100, 200) : n - plen;
                    make_text(n, TEXT_PLANTED, at);
                end else begin
                    n    = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(1, 12);
                    mode = t_text_mode'($urandom_range(0, 2));
                    at   = (n >= plen) ? $urandom_range(0, n - plen) : 0;
                    make_text(n, mode, at);
                end
                if (t == texts - 1 && n > 1 && $urandom_range(0, 5) == 0) begin
                    send_text(1'b0);
                    open_text = 1'b1;
                end else begin
                    send_text(1'b1);
                end
            end
            phase++;
        end
        if (open_text) begin
            make_text(1, TEXT_NOISE, 0);
            send_text(1'b1);
        end

        // Drain every outstanding score, then give the output register a few more cycles
        // to show any stray word before the verdict.
        idling_on = 1'b0;
        wait_idle();
        repeat (5) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("fuzzy_pattern_match_scorer verification clean");
        end else begin
            $display("fuzzy_pattern_match_scorer verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/fpms_pkg.sv
design/fpms_if.sv
design/fpms_cell.sv
design/fpms_seq.sv
design/fuzzy_pattern_match_scorer.sv
bench/fuzzy_score_checker.sv
bench/fuzzy_pattern_match_scorer_tb.sv
